/* hdl/eabb_pkg.sv */
`default_nettype none
package eabb_pkg;

  // Frame geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int EFFW_W    = ADDR_W + 1;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 16;

  // Pixel and arithmetic widths
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int SUM_W     = 12;          // 9 * 255 fits
  localparam int CNT_W     = 4;           // neighbor count up to 9
  localparam int NUM_W     = SUM_W + 1;   // 2*sum + count
  localparam int DV_W      = CNT_W + 1;   // 2*count
  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // One result to compute: which window columns and rows take part
  typedef struct packed {
    logic [2:0] col_en;
    logic [2:0] row_en;
    logic       last;
    logic       fend;
  } emit_t;

  // Controller to datapath
  typedef struct packed {
    logic              cap_pix;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              shift;
    logic              bot_pix;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              sum_go;
    logic [2:0]        col_en;
    logic [2:0]        row_en;
    logic              div_step;
    logic              load_out;
    logic              last;
    logic              fend;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* hdl/eabb_dp.sv */
`default_nettype none
module eabb_dp (
  input  logic                clk,
  input  logic                rst,
  input  eabb_pkg::cmd_t      cmd,
  output eabb_pkg::sts_t      sts,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic                last_of_run,
  output logic                frame_end
);
  import eabb_pkg::*;

  // Line stores: older row and newer row
  logic [PIX_W-1:0] ls_top [MAX_WIDTH];
  logic [PIX_W-1:0] ls_mid [MAX_WIDTH];
  logic [PIX_W-1:0] top_q;
  logic [PIX_W-1:0] mid_q;
  logic [PIX_W-1:0] pix_q;

  logic [PIX_W-1:0] win [3][3];
  logic [PIX_W-1:0] ins [3];

  logic [SUM_W-1:0] sum [3];
  logic [CNT_W-1:0] cnt;

  logic [NUM_W-1:0] num [3];
  logic [DV_W-1:0]  rem [3];
  logic [NUM_W-1:0] quo [3];
  logic [DV_W-1:0]  dv;
  logic [DV_W:0]    trial [3];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      ls_top[cmd.wr_addr] <= mid_q;
      ls_mid[cmd.wr_addr] <= pix_q;
    end
    if (cmd.rd_en) begin
      top_q <= ls_top[cmd.rd_addr];
      mid_q <= ls_mid[cmd.rd_addr];
    end
  end

  // Incoming pixel capture
  always_ff @(posedge clk) begin
    if (cmd.cap_pix) begin
      pix_q <= {in_red, in_green, in_blue};
    end
  end

  // 3x3 window, shifts left, new column enters at the right
  assign ins[0] = top_q;
  assign ins[1] = mid_q;
  assign ins[2] = cmd.bot_pix ? pix_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
        win[r][2] <= ins[r];
      end
    end
  end

  // Masked channel sums and neighbor count
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
    end
    cnt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (cmd.row_en[r] && cmd.col_en[c]) begin
          cnt = cnt + CNT_W'(1);
          for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = sum[ch] + SUM_W'(win[r][c][(2-ch)*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  // Restoring divider, one quotient bit per step, three channels side by side
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      trial[ch] = {rem[ch], num[ch][NUM_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_go) begin
      dv <= {cnt, 1'b0};
      for (int ch = 0; ch < 3; ch++) begin
        num[ch] <= {sum[ch], 1'b0} + NUM_W'(cnt);
        rem[ch] <= '0;
        quo[ch] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        num[ch] <= num[ch] << 1;
        if (trial[ch] >= {1'b0, dv}) begin
          rem[ch] <= DV_W'(trial[ch] - {1'b0, dv});
          quo[ch] <= {quo[ch][NUM_W-2:0], 1'b1};
        end else begin
          rem[ch] <= trial[ch][DV_W-1:0];
          quo[ch] <= {quo[ch][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // Output register
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_red     <= quo[0][CH_W-1:0];
      out_green   <= quo[1][CH_W-1:0];
      out_blue    <= quo[2][CH_W-1:0];
      last_of_run <= cmd.last;
      frame_end   <= cmd.fend;
    end
  end

endmodule
`default_nettype wire

/* hdl/eabb_ctrl.sv */
`default_nettype none
module eabb_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [eabb_pkg::EFFW_W-1:0]   eff_w,
  input  logic [eabb_pkg::HEIGHT_W-1:0] eff_h,
  input  logic                          cfg_wr,
  input  eabb_pkg::sts_t                sts,
  output eabb_pkg::cmd_t                cmd
);
  import eabb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PSHIFT,
    S_DRD,
    S_SUM,
    S_DIV,
    S_OUT
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   col_cnt;
  logic [HEIGHT_W-1:0] row_cnt;
  logic [ADDR_W-1:0]   drn_cnt;
  logic [ADDR_W-1:0]   pos;
  logic [1:0]          k;
  logic [DCNT_W-1:0]   div_cnt;
  emit_t               em;
  emit_t               em2;
  logic                pend2;
  logic                has_emit;

  logic        pix_ok;
  logic        drn_ok;
  logic        last_col;
  logic        gen1;
  logic        gen2;
  logic        drn_last;
  emit_t       e1;
  emit_t       e2;
  emit_t       ed;

  // Item decode against the frame position
  always_comb begin
    pix_ok   = (command == CMD_PIXEL) && (row_cnt < eff_h);
    drn_ok   = (command == CMD_DRAIN) && (row_cnt >= eff_h)
               && (EFFW_W'(drn_cnt) < eff_w);
    last_col = (EFFW_W'(col_cnt) + EFFW_W'(1)) == eff_w;
    gen1     = (row_cnt != '0) && (col_cnt != '0);
    gen2     = (row_cnt != '0) && last_col;
    drn_last = (EFFW_W'(drn_cnt) + EFFW_W'(1)) == eff_w;

    // Result for the column left of the new pixel
    e1.col_en = {1'b1, 1'b1, (col_cnt >= ADDR_W'(2))};
    e1.row_en = {1'b1, 1'b1, (row_cnt >= HEIGHT_W'(2))};
    e1.last   = !last_col;
    e1.fend   = 1'b0;
    // Result for the last column of the row
    e2.col_en = {1'b1, (eff_w >= EFFW_W'(2)), 1'b0};
    e2.row_en = {1'b1, 1'b1, (row_cnt >= HEIGHT_W'(2))};
    e2.last   = 1'b1;
    e2.fend   = 1'b0;
    // Bottom row result
    ed.col_en = {!drn_last, 1'b1, (drn_cnt != '0)};
    ed.row_en = {1'b0, 1'b1, (eff_h >= HEIGHT_W'(2))};
    ed.last   = 1'b1;
    ed.fend   = drn_last;
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.cap_pix = in_valid && pix_ok;
        cmd.rd_en   = in_valid && (pix_ok || drn_ok);
        cmd.rd_addr = pix_ok ? col_cnt : drn_cnt - ADDR_W'(1);
      end
      S_PSHIFT: begin
        cmd.shift   = 1'b1;
        cmd.bot_pix = 1'b1;
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = pos;
      end
      S_DRD: begin
        cmd.shift   = 1'b1;
        cmd.rd_en   = (k != 2'd2);
        cmd.rd_addr = pos + ADDR_W'(k);
      end
      S_SUM: begin
        cmd.sum_go = 1'b1;
        cmd.col_en = em.col_en;
        cmd.row_en = em.row_en;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_OUT: begin
        cmd.load_out = sts.out_free;
        cmd.last     = em.last;
        cmd.fend     = em.fend;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State, frame counters and pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      col_cnt  <= '0;
      row_cnt  <= '0;
      drn_cnt  <= '0;
      k        <= '0;
      div_cnt  <= '0;
      pend2    <= 1'b0;
      has_emit <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && pix_ok) begin
            pos      <= col_cnt;
            em       <= gen1 ? e1 : e2;
            em2      <= e2;
            pend2    <= gen1 && gen2;
            has_emit <= gen1 || gen2;
            if (last_col) begin
              col_cnt <= '0;
              if (row_cnt != '1) begin
                row_cnt <= row_cnt + HEIGHT_W'(1);
              end
            end else begin
              col_cnt <= col_cnt + ADDR_W'(1);
            end
            state <= S_PSHIFT;
          end else if (in_valid && drn_ok) begin
            pos   <= drn_cnt;
            em    <= ed;
            pend2 <= 1'b0;
            k     <= '0;
            if (drn_last) begin
              drn_cnt <= '0;
              col_cnt <= '0;
              row_cnt <= '0;
            end else begin
              drn_cnt <= drn_cnt + ADDR_W'(1);
            end
            state <= S_DRD;
          end
        end
        S_PSHIFT: begin
          state <= has_emit ? S_SUM : S_IDLE;
        end
        S_DRD: begin
          k <= k + 2'd1;
          if (k == 2'd2) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (sts.out_free) begin
            if (pend2) begin
              em    <= em2;
              pend2 <= 1'b0;
              state <= S_SUM;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // a register write restarts the frame
      if (cfg_wr) begin
        col_cnt <= '0;
        row_cnt <= '0;
        drn_cnt <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/edge_aware_box_blur_3x3_unit.sv */
// A pixel that yields a result passes the window shift, the sum and the divider
// steps, then loads the output register; a second result of the same pixel runs
// sum and divider again. A drain first refills the window from the line stores.
// Items are taken one at a time; the 13-step shared divider sets the pace.
// Reset (rst, synchronous): counters, handshake and config registers return to defaults;
// line stores, window and datapath data registers are not cleared.
`default_nettype none
module edge_aware_box_blur_3x3_unit (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        last_of_run,
  output logic        frame_end,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import eabb_pkg::*;

  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [EFFW_W-1:0]   eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic                cfg_wr;
  cmd_t                cmd;
  sts_t                sts;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_W'(MAX_WIDTH);
      frame_height <= HEIGHT_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  frame_width  <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[HEIGHT_W-1:0];
        default:    frame_width  <= frame_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(frame_width);
      REG_HEIGHT: prdata = 32'(frame_height);
      default:    prdata = '0;
    endcase
  end

  // Working geometry: zero acts as one, width clamps to the line store
  always_comb begin
    if (frame_width == '0) begin
      eff_w = EFFW_W'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = EFFW_W'(MAX_WIDTH);
    end else begin
      eff_w = EFFW_W'(frame_width);
    end
    eff_h = (frame_height == '0) ? HEIGHT_W'(1) : frame_height;
  end

  eabb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .cfg_wr   (cfg_wr),
    .sts      (sts),
    .cmd      (cmd)
  );

  eabb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .last_of_run (last_of_run),
    .frame_end   (frame_end)
  );

`ifndef SYNTH
  // the corner result always closes its run
  a_fend_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> last_of_run)
    else $error("frame_end without last_of_run");

  // every result includes its center pixel (middle or right window column),
  // so the divisor is never zero
  a_center: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_go |-> (cmd.row_en[1] && (cmd.col_en[1] || cmd.col_en[2])))
    else $error("sum without center pixel");

  // line stores are only written while no transfer can be taken
  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> in_stall)
    else $error("line store write while accepting");

  // a new result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output overwritten");
`endif

endmodule
`default_nettype wire
